/* rtl/scwb_pkg.sv */
package scwb_pkg;

    localparam int MAX_SPRITES = 8;
    localparam int ADDR_W      = 21;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 21;
    localparam int SPAN_W      = 16;
    localparam int COUNT_W     = 4;

    // The divider retires two quotient bits per cycle.
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES         = SPAN_W / DIV_BITS_PER_CYCLE;
    localparam logic [2:0] DIV_LAST_STEP = 3'(DIV_CYCLES - 1);

    localparam logic [15:0] DIW_START_RST     = 16'h2C81;
    localparam logic [8:0]  PANE_TOP_RST      = 9'd0;
    localparam logic [8:0]  PANE_ROWS_RST     = 9'd256;
    localparam logic [2:0]  FETCH_FACTOR_RST  = 3'd1;
    localparam logic [3:0]  AVAIL_SPRITES_RST = 4'd8;
    localparam logic [20:0] NULL_ADDR_RST     = 21'd0;

    // Start rows from this value upwards park the sprites on the null sprite.
    localparam logic signed [11:0] NULL_START_ROW = 12'sd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIW_START,
        CFG_PANE_TOP,
        CFG_PANE_ROWS,
        CFG_FETCH_FACTOR,
        CFG_AVAIL_SPRITES,
        CFG_NULL_ADDR
    } cfg_index_t;

    typedef struct packed {
        logic [15:0]       diw_start;
        logic [8:0]        pane_top;
        logic [8:0]        pane_rows;
        logic [2:0]        fetch_factor;
        logic [3:0]        avail_sprites;
        logic [ADDR_W-1:0] null_addr;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEOM,
        ST_CLIP,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic geom;
        logic clip;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic div_done;
        logic out_busy;
        logic last;
    } status_t;

endpackage

/* rtl/sprite_control_word_builder.sv */
// Sprite control word builder.
// A placement request enters on the in_valid/in_ready channel, one field per
// port. It yields between zero and eight results on the out_valid/out_ready
// channel, one per hardware sprite, the final one flagged by last.
// Registers are written through the cfg_valid/cfg_ready channel, cfg_index
// selecting the register and cfg_data carrying the value; cfg_ready is always
// high and writes are expected only while no request is in flight.
// Flow: the divider that works out the per-sprite data size at two quotient
// bits a cycle runs while the request passes the geometry and clip states,
// and results are emitted once it is done; after that one result leaves per
// cycle while the receiver takes them. A request that produces no result
// leaves the block after the clip state.
// A stalled receiver holds the pending result in the output register and the
// sequence simply pauses; a new request is taken as soon as the last result
// has been loaded, even if it has not yet been collected.
// Reset returns the controller to idle, empties the output register and
// loads the registers with their power-on values.
module sprite_control_word_builder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scwb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scwb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [10:0]                pos_x,
    input  logic signed [10:0]                pos_y,
    input  logic signed [7:0]                 hot_x,
    input  logic signed [7:0]                 hot_y,
    input  logic [9:0]                        image_height,
    input  logic signed [3:0]                 requested_sprite,
    input  logic [2:0]                        default_sprite,
    input  logic [scwb_pkg::ADDR_W-1:0]       data_start,
    input  logic [scwb_pkg::SPAN_W-1:0]       bank_span,
    input  logic [7:0]                        layout,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              kind,
    output logic [2:0]                        sprite_index,
    output logic [15:0]                       pos_word,
    output logic [15:0]                       ctl_word,
    output logic [scwb_pkg::ADDR_W-1:0]       data_address,
    output logic                              last
);
    import scwb_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    scwb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    scwb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    scwb_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg              (cfg),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .hot_x            (hot_x),
        .hot_y            (hot_y),
        .image_height     (image_height),
        .requested_sprite (requested_sprite),
        .default_sprite   (default_sprite),
        .data_start       (data_start),
        .bank_span        (bank_span),
        .layout           (layout),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .kind             (kind),
        .sprite_index     (sprite_index),
        .pos_word         (pos_word),
        .ctl_word         (ctl_word),
        .data_address     (data_address),
        .last             (last)
    );

endmodule

/* rtl/scwb_cfg.sv */
module scwb_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scwb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scwb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output scwb_pkg::cfg_t                    cfg
);
    import scwb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DIW_START:     cfg_next.diw_start     = cfg_data[15:0];
                CFG_PANE_TOP:      cfg_next.pane_top      = cfg_data[8:0];
                CFG_PANE_ROWS:     cfg_next.pane_rows     = cfg_data[8:0];
                CFG_FETCH_FACTOR:  cfg_next.fetch_factor  = cfg_data[2:0];
                CFG_AVAIL_SPRITES: cfg_next.avail_sprites = cfg_data[3:0];
                CFG_NULL_ADDR:     cfg_next.null_addr     = cfg_data[ADDR_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.diw_start     <= DIW_START_RST;
            cfg_reg.pane_top      <= PANE_TOP_RST;
            cfg_reg.pane_rows     <= PANE_ROWS_RST;
            cfg_reg.fetch_factor  <= FETCH_FACTOR_RST;
            cfg_reg.avail_sprites <= AVAIL_SPRITES_RST;
            cfg_reg.null_addr     <= NULL_ADDR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/scwb_div.sv */
module scwb_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [scwb_pkg::SPAN_W-1:0]      dividend,
    input  logic [scwb_pkg::COUNT_W-1:0]     divisor,
    output logic                             done,
    output logic [scwb_pkg::SPAN_W-1:0]      quotient
);
    import scwb_pkg::*;

    logic [SPAN_W-1:0]  q_reg, q_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] d_reg, d_next;
    logic [2:0]         step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [COUNT_W:0]   r1, r2;
    logic               ge1, ge2;
    logic [COUNT_W-1:0] rem1, rem2;

    // Two restoring division steps per cycle; the remainder stays below the divisor.
    always_comb
    begin
        r1   = {rem_reg, q_reg[SPAN_W-1]};
        ge1  = r1 >= {1'b0, d_reg};
        rem1 = ge1 ? COUNT_W'(r1 - {1'b0, d_reg}) : r1[COUNT_W-1:0];
        r2   = {rem1, q_reg[SPAN_W-2]};
        ge2  = r2 >= {1'b0, d_reg};
        rem2 = ge2 ? COUNT_W'(r2 - {1'b0, d_reg}) : r2[COUNT_W-1:0];
    end

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            q_next    = {q_reg[SPAN_W-3:0], ge1, ge2};
            rem_next  = rem2;
            step_next = step_reg + 3'd1;
            if (step_reg == DIV_LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/scwb_ctrl.sv */
module scwb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  scwb_pkg::status_t status,
    output scwb_pkg::cmd_t    cmd
);
    import scwb_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_GEOM;
                end
            end
            ST_GEOM:
            begin
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                state_next = status.skip ? ST_IDLE : ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!status.out_busy && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_GEOM:
            begin
                cmd.geom = 1'b1;
            end
            ST_CLIP:
            begin
                cmd.clip = 1'b1;
            end
            ST_DIV:
            begin
                cmd = '0;
            end
            ST_EMIT:
            begin
                cmd.emit = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/scwb_datapath.sv */
module scwb_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  scwb_pkg::cmd_t                      cmd,
    output scwb_pkg::status_t                   status,
    input  scwb_pkg::cfg_t                      cfg,
    input  logic signed [10:0]                  pos_x,
    input  logic signed [10:0]                  pos_y,
    input  logic signed [7:0]                   hot_x,
    input  logic signed [7:0]                   hot_y,
    input  logic [9:0]                          image_height,
    input  logic signed [3:0]                   requested_sprite,
    input  logic [2:0]                          default_sprite,
    input  logic [scwb_pkg::ADDR_W-1:0]         data_start,
    input  logic [scwb_pkg::SPAN_W-1:0]         bank_span,
    input  logic [7:0]                          layout,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic                                kind,
    output logic [2:0]                          sprite_index,
    output logic [15:0]                         pos_word,
    output logic [15:0]                         ctl_word,
    output logic [scwb_pkg::ADDR_W-1:0]         data_address,
    output logic                                last
);
    import scwb_pkg::*;

    // Request captured on the input transaction.
    logic [10:0]        px_reg, py_reg;
    logic [7:0]         hx_reg, hy_reg;
    logic [9:0]         height_reg;
    logic [2:0]         first_reg;
    logic [3:0]         count_reg;
    logic               attached_reg;
    logic [ADDR_W-1:0]  data_reg;

    // Geometry stage.
    logic               skip_reg, null_reg, neg_reg;
    logic [3:0]         cnt_reg;
    logic [11:0]        y_reg;
    logic [8:0]         x0_reg;
    logic [10:0]        clip1_reg;
    logic [15:0]        prod_reg;
    logic [9:0]         base_reg;

    // Clip stage and per-sprite state.
    logic [7:0]         pos_hi_reg;
    logic [15:0]        ctl0_reg;
    logic [2:0]         k_reg;
    logic [8:0]         hstart_reg;
    logic [ADDR_W-1:0]  addr_reg;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic               kind_reg;
    logic [2:0]         idx_reg;
    logic [15:0]        pos_reg, ctl_reg;
    logic [ADDR_W-1:0]  addr_out_reg;
    logic               last_reg;

    logic               div_done;
    logic [SPAN_W-1:0]  ssize;

    logic [3:0]         avail;
    logic               first_ge;
    logic [4:0]         cnt_sum;
    logic [3:0]         cnt_trim;
    logic [11:0]        y_sum;
    logic               ge_ph, is_null, neg;
    logic [11:0]        clip1;
    logic               top_empty;
    logic [10:0]        negy;
    logic [15:0]        prod;
    logic [8:0]         x0;
    logic [9:0]         base;

    logic [9:0]         ytop;
    logic [10:0]        rows;
    logic [7:0]         yy;
    logic [10:0]        bot;
    logic [9:0]         clipped;
    logic [10:0]        ystop;
    logic [15:0]        ctl0;
    logic [ADDR_W-1:0]  saddr;

    logic [8:0]         glue;
    logic               step_adv;
    logic               is_last;

    scwb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.accept),
        .dividend (bank_span),
        .divisor  (layout[3:0]),
        .done     (div_done),
        .quotient (ssize)
    );

    // Geometry: sprite range, start row, horizontal start and the rows lost above the panel.
    always_comb
    begin
        avail     = (cfg.avail_sprites > 4'(MAX_SPRITES)) ? 4'(MAX_SPRITES)
                                                          : cfg.avail_sprites;
        first_ge  = {1'b0, first_reg} >= avail;
        cnt_sum   = {2'b00, first_reg} + {1'b0, count_reg};
        cnt_trim  = (cnt_sum > {1'b0, avail}) ? (avail - {1'b0, first_reg}) : count_reg;
        y_sum     = {py_reg[10], py_reg} + {{4{hy_reg[7]}}, hy_reg};
        ge_ph     = $signed(y_sum) >= $signed({3'b000, cfg.pane_rows});
        is_null   = $signed(y_sum) >= NULL_START_ROW;
        neg       = y_sum[11];
        clip1     = {2'b00, height_reg} + y_sum;
        top_empty = neg && ($signed(clip1) < 12'sd1);
        negy      = 11'(-y_sum);
        prod      = {3'b000, negy, 2'b00} * {13'd0, cfg.fetch_factor};
        x0        = px_reg[8:0] + {hx_reg[7], hx_reg} + {1'b0, cfg.diw_start[7:0]} - 9'd1;
        base      = {2'b00, cfg.diw_start[15:8]} + {1'b0, cfg.pane_top};
    end

    // Clip: vertical start and stop, the control word and the first data address.
    always_comb
    begin
        ytop    = neg_reg ? base_reg : base_reg + {2'b00, y_reg[7:0]};
        rows    = neg_reg ? clip1_reg : {1'b0, height_reg};
        yy      = neg_reg ? 8'd0 : y_reg[7:0];
        bot     = {3'b000, yy} + rows;
        clipped = (bot > {2'b00, cfg.pane_rows})
                  ? 10'({1'b0, cfg.pane_rows} - {2'b00, yy}) : rows[9:0];
        ystop   = {1'b0, ytop} + {1'b0, clipped};
        ctl0    = {ystop[7:0], attached_reg, 3'b000,
                   ({ytop[9:8], 2'b00} | {ystop[10:8], 1'b0})};
        saddr   = neg_reg ? data_reg + {5'd0, prod_reg} : data_reg;
    end

    always_comb
    begin
        glue     = {2'b00, cfg.fetch_factor, 4'b0000};
        step_adv = !attached_reg || k_reg[0];
        is_last  = ({1'b0, k_reg} + 4'd1) == cnt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg       <= pos_x;
            py_reg       <= pos_y;
            hx_reg       <= hot_x;
            hy_reg       <= hot_y;
            height_reg   <= image_height;
            first_reg    <= requested_sprite[3] ? default_sprite : requested_sprite[2:0];
            count_reg    <= layout[3:0];
            attached_reg <= layout[4];
            data_reg     <= data_start;
        end
        if (cmd.geom)
        begin
            skip_reg  <= first_ge || (count_reg == 4'd0) || ge_ph || (!is_null && top_empty);
            null_reg  <= is_null;
            neg_reg   <= neg;
            cnt_reg   <= cnt_trim;
            y_reg     <= y_sum;
            x0_reg    <= x0;
            clip1_reg <= clip1[10:0];
            prod_reg  <= prod;
            base_reg  <= base;
        end
        if (cmd.clip)
        begin
            pos_hi_reg <= ytop[7:0];
            ctl0_reg   <= ctl0;
            k_reg      <= '0;
            hstart_reg <= x0_reg;
            addr_reg   <= saddr;
        end
        if (cmd.emit)
        begin
            kind_reg     <= null_reg;
            idx_reg      <= first_reg + k_reg;
            pos_reg      <= null_reg ? 16'd0 : {pos_hi_reg, hstart_reg[8:1]};
            ctl_reg      <= null_reg ? 16'd0 : {ctl0_reg[15:1], hstart_reg[0]};
            addr_out_reg <= null_reg ? cfg.null_addr : addr_reg;
            last_reg     <= is_last;
            k_reg        <= k_reg + 3'd1;
            addr_reg     <= addr_reg + {5'd0, ssize};
            if (step_adv)
            begin
                hstart_reg <= hstart_reg + glue;
            end
        end
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.skip     = skip_reg;
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !out_ready;
    assign status.last     = is_last;

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign sprite_index = idx_reg;
    assign pos_word     = pos_reg;
    assign ctl_word     = ctl_reg;
    assign data_address = addr_out_reg;
    assign last         = last_reg;

endmodule

/* dv/testbench.sv */
module testbench;

    import scwb_pkg::*;

    localparam int RUN_LIMIT    = 500000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int END_LIMIT    = 20000;
    localparam int PRINT_LIMIT  = 200;

    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_NULL = 1'b1;

    localparam int unsigned ADDR_MASK = (1 << ADDR_W) - 1;

    typedef struct {
        logic signed [10:0] pos_x;
        logic signed [10:0] pos_y;
        logic signed [7:0]  hot_x;
        logic signed [7:0]  hot_y;
        logic [9:0]         image_height;
        logic signed [3:0]  requested_sprite;
        logic [2:0]         default_sprite;
        logic [ADDR_W-1:0]  data_start;
        logic [SPAN_W-1:0]  bank_span;
        logic [7:0]         layout;
    } sprite_request_t;

    typedef struct {
        logic              kind;
        logic [2:0]        sprite_index;
        logic [15:0]       pos_word;
        logic [15:0]       ctl_word;
        logic [ADDR_W-1:0] data_address;
        logic              last;
    } sprite_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [10:0]    pos_x = '0;
    logic signed [10:0]    pos_y = '0;
    logic signed [7:0]     hot_x = '0;
    logic signed [7:0]     hot_y = '0;
    logic [9:0]            image_height = '0;
    logic signed [3:0]     requested_sprite = '0;
    logic [2:0]            default_sprite = '0;
    logic [ADDR_W-1:0]     data_start = '0;
    logic [SPAN_W-1:0]     bank_span = '0;
    logic [7:0]            layout = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  kind;
    logic [2:0]            sprite_index;
    logic [15:0]           pos_word;
    logic [15:0]           ctl_word;
    logic [ADDR_W-1:0]     data_address;
    logic                  last;

    // Shadow copy of the register file, updated at each write transaction.
    cfg_t model_cfg = '{DIW_START_RST, PANE_TOP_RST, PANE_ROWS_RST,
                        FETCH_FACTOR_RST, AVAIL_SPRITES_RST, NULL_ADDR_RST};

    sprite_word_t pending_words[$];

    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  requests_sent = 0;
    int  words_checked = 0;
    int  regs_written = 0;
    int  settings_applied = 0;
    bit  calm_tail = 1'b0;
    bit  sender_steady = 1'b0;
    bit  sink_hold_req = 1'b0;

    sprite_control_word_builder u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .hot_x            (hot_x),
        .hot_y            (hot_y),
        .image_height     (image_height),
        .requested_sprite (requested_sprite),
        .default_sprite   (default_sprite),
        .data_start       (data_start),
        .bank_span        (bank_span),
        .layout           (layout),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .sprite_index     (sprite_index),
        .pos_word         (pos_word),
        .ctl_word         (ctl_word),
        .data_address     (data_address),
        .last             (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_words.size());
            $display("[sprite_control_word_builder] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("Mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                     what, words_checked, got, want);
    endtask

    // Works out the hardware sprite words that one request produces under the
    // current register settings and queues them in order.
    function automatic void predict_sprite_words(input sprite_request_t r);
        int          px, py, hx, hy, rows, req, x0, y, clipped;
        int unsigned avail, first, count, ssize, glue, saddr, ytop, ystop, ctl0;
        int unsigned col_step, hstart, fm, vstart, k;
        bit          attached;
        sprite_word_t w;

        px   = r.pos_x;
        py   = r.pos_y;
        hx   = r.hot_x;
        hy   = r.hot_y;
        rows = r.image_height;
        req  = r.requested_sprite;
        avail = (model_cfg.avail_sprites > MAX_SPRITES) ? MAX_SPRITES
                                                        : model_cfg.avail_sprites;
        first    = (req < 0) ? r.default_sprite : req;
        count    = r.layout[3:0];
        attached = r.layout[4];

        if (first >= avail || count == 0)
            return;
        ssize = r.bank_span / count;
        if (first + count > avail)
            count = avail - first;

        fm     = model_cfg.fetch_factor;
        vstart = model_cfg.diw_start[15:8];
        x0     = px + hx + int'(model_cfg.diw_start[7:0]) - 1;
        y      = py + hy;
        if (y >= int'(model_cfg.pane_rows))
            return;

        // Sprites that would start too low are parked on the blank sprite.
        if (y >= 255)
        begin
            for (k = 0; k < count; k++)
            begin
                w.kind         = KIND_NULL;
                w.sprite_index = 3'(first + k);
                w.pos_word     = '0;
                w.ctl_word     = '0;
                w.data_address = model_cfg.null_addr;
                w.last         = (k + 1 == count);
                pending_words.push_back(w);
            end
            return;
        end

        if (y < 0)
        begin
            ytop    = vstart + model_cfg.pane_top;
            clipped = rows + y;
            if (clipped < 1)
                return;
            saddr = (r.data_start + (-y) * (fm << 2)) & ADDR_MASK;
            y     = 0;
        end
        else
        begin
            ytop    = y + vstart + model_cfg.pane_top;
            clipped = rows;
            saddr   = r.data_start;
        end
        if (y + clipped > int'(model_cfg.pane_rows))
            clipped = int'(model_cfg.pane_rows) - y;
        ystop = ytop + clipped;

        ctl0 = ((ystop & 32'hFF) << 8) | ((ytop >> 8) << 2) | ((ystop >> 8) << 1);
        if (attached)
            ctl0 = ctl0 | 32'h80;
        glue = fm << 4;

        for (k = 0; k < count; k++)
        begin
            col_step       = attached ? (k >> 1) : k;
            hstart         = (x0 + col_step * glue) & 32'h1FF;
            w.kind         = KIND_SET;
            w.sprite_index = 3'(first + k);
            w.pos_word     = 16'(((ytop & 32'hFF) << 8) | (hstart >> 1));
            w.ctl_word     = 16'(ctl0 | (hstart & 32'h1));
            w.data_address = ADDR_W'(saddr + k * ssize);
            w.last         = (k + 1 == count);
            pending_words.push_back(w);
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        sprite_word_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                report_mismatch("unexpected result, sprite_index", sprite_index, 0);
            end
            else
            begin
                want = pending_words.pop_front();
                if (kind !== want.kind)
                    report_mismatch("kind", kind, want.kind);
                if (sprite_index !== want.sprite_index)
                    report_mismatch("sprite_index", sprite_index, want.sprite_index);
                if (pos_word !== want.pos_word)
                    report_mismatch("pos_word", pos_word, want.pos_word);
                if (ctl_word !== want.ctl_word)
                    report_mismatch("ctl_word", ctl_word, want.ctl_word);
                if (data_address !== want.data_address)
                    report_mismatch("data_address", data_address, want.data_address);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
            words_checked++;
        end
    end

    // Receiver pacing: random ready and stall bursts, plus one long hold-off
    // on request so that the block backs up into its input.
    initial
    begin : sink_pacing
        int held;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold_req)
            begin
                out_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                sink_hold_req = 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    task automatic send_request(input sprite_request_t r);
        pos_x            <= r.pos_x;
        pos_y            <= r.pos_y;
        hot_x            <= r.hot_x;
        hot_y            <= r.hot_y;
        image_height     <= r.image_height;
        requested_sprite <= r.requested_sprite;
        default_sprite   <= r.default_sprite;
        data_start       <= r.data_start;
        bank_span        <= r.bank_span;
        layout           <= r.layout;
        in_valid         <= 1'b1;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        predict_sprite_words(r);
        requests_sent++;
        if (!calm_tail && !sender_steady && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic send_case(input int px, input int py, input int hx, input int hy,
                             input int rows, input int req, input int defs,
                             input int unsigned data, input int unsigned span,
                             input int unsigned lay);
        sprite_request_t r;
        r.pos_x            = 11'(px);
        r.pos_y            = 11'(py);
        r.hot_x            = 8'(hx);
        r.hot_y            = 8'(hy);
        r.image_height     = 10'(rows);
        r.requested_sprite = 4'(req);
        r.default_sprite   = 3'(defs);
        r.data_start       = ADDR_W'(data);
        r.bank_span        = SPAN_W'(span);
        r.layout           = 8'(lay);
        send_request(r);
    endtask

    // Most requests land in or near the panel with a sensible count; the rest
    // are fully random noise.
    function automatic sprite_request_t random_request(input bit aimed);
        sprite_request_t r;
        int              target;
        r.pos_x            = 11'($urandom);
        r.pos_y            = 11'($urandom);
        r.hot_x            = 8'($urandom);
        r.hot_y            = 8'($urandom);
        r.image_height     = 10'($urandom);
        r.requested_sprite = 4'($urandom);
        r.default_sprite   = 3'($urandom);
        r.data_start       = ADDR_W'($urandom);
        r.bank_span        = SPAN_W'($urandom);
        r.layout           = 8'($urandom);
        if (aimed)
        begin
            target  = int'($urandom_range(0, model_cfg.pane_rows + 80)) - 60;
            r.pos_y = 11'(target - int'(r.hot_y));
            if ($urandom_range(0, 3) != 0)
                r.image_height = 10'($urandom_range(0, 64));
            if ($urandom_range(0, 3) == 0)
                r.requested_sprite = -4'sd1;
            else
                r.requested_sprite = 4'($urandom_range(0, 7));
            if ($urandom_range(0, 5) == 0)
                r.layout[3:0] = 4'($urandom_range(9, 15));
            else
                r.layout[3:0] = 4'($urandom_range(1, 8));
        end
        return r;
    endfunction

    task automatic send_random(input int n, input int noise_one_in);
        int i;
        for (i = 0; i < n; i++)
            send_request(random_request($urandom_range(1, noise_one_in) != 1));
    endtask

    // Lowers the request valid and waits until every expected result has been
    // collected and any result-free request has left the block.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        case (idx)
            CFG_DIW_START:     model_cfg.diw_start     = value[15:0];
            CFG_PANE_TOP:      model_cfg.pane_top      = value[8:0];
            CFG_PANE_ROWS:     model_cfg.pane_rows     = value[8:0];
            CFG_FETCH_FACTOR:  model_cfg.fetch_factor  = value[2:0];
            CFG_AVAIL_SPRITES: model_cfg.avail_sprites = value[3:0];
            CFG_NULL_ADDR:     model_cfg.null_addr     = value[ADDR_W-1:0];
            default: ;
        endcase
        regs_written++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input int unsigned diw, input int unsigned pstart,
                                  input int unsigned pheight, input int unsigned fm,
                                  input int unsigned avail, input int unsigned null_addr);
        wait_until_drained();
        write_register(CFG_DIW_START,     CFG_DATA_W'(diw));
        write_register(CFG_PANE_TOP,      CFG_DATA_W'(pstart));
        write_register(CFG_PANE_ROWS,     CFG_DATA_W'(pheight));
        write_register(CFG_FETCH_FACTOR,  CFG_DATA_W'(fm));
        write_register(CFG_AVAIL_SPRITES, CFG_DATA_W'(avail));
        write_register(CFG_NULL_ADDR,     CFG_DATA_W'(null_addr));
        settings_applied++;
    endtask

    task automatic restore_defaults();
        apply_settings(DIW_START_RST, PANE_TOP_RST, PANE_ROWS_RST,
                       FETCH_FACTOR_RST, AVAIL_SPRITES_RST, NULL_ADDR_RST);
    endtask

    task automatic test_directed_cases();
        send_case(100, 50, 0, 0, 16, 0, 0, 'h001000, 64, 'h01);
        send_case(10, 20, 3, 4, 8, -1, 5, 'h002000, 100, 'h02);
        send_case(-200, 30, -128, 127, 40, 2, 0, 'h030000, 1000, 'h14);
        send_case(0, 60, 127, 0, 12, 4, 0, 'h040000, 999, 'h13);
        // Count runs past the last hardware sprite and gets trimmed.
        send_case(50, 10, 0, 0, 5, 6, 0, 'h050000, 800, 'h08);
        send_case(50, 10, 0, 0, 5, 1, 0, 0, 0, 'h00);
        send_case(50, 10, 0, 0, 5, 1, 0, 0, 0, 'hE0);
        send_case(50, 256, 0, 0, 5, 0, 0, 0, 0, 'h01);
        send_case(50, 1023, 127, 127, 5, 0, 0, 0, 0, 'h03);
        // Start rows of 255 and above produce null-sprite resets.
        send_case(50, 255, 0, 0, 30, 5, 0, 'h060000, 300, 'h05);
        send_case(50, 200, 0, 55, 30, 0, 0, 0, 300, 'h12);
        send_case(80, -5, 0, 0, 20, 0, 0, 'h070000, 64, 'h02);
        send_case(80, -20, 0, 0, 20, 0, 0, 'h070000, 64, 'h02);
        send_case(80, -1024, 0, -128, 1023, 0, 0, 0, 64, 'h01);
        send_case(80, 0, 0, -100, 1023, 0, 0, 'h1FFFF0, 'hFFFF, 'h08);
        send_case(80, 250, 0, 0, 100, 3, 0, 'h080000, 256, 'h01);
        send_case(80, 10, 0, 0, 0, 3, 0, 'h080000, 256, 'h01);
        // Horizontal start wrapping both ways.
        send_case(-1024, 40, -128, 0, 8, 0, 0, 'h000100, 32, 'h04);
        send_case(1023, 40, 127, 0, 8, 0, 0, 'h000100, 32, 'h04);
        send_case(0, 0, 0, 0, 1, -8, 7, 'h1FFFFF, 'hFFFF, 'hFF);
        send_case(511, 100, -1, 0, 1023, 7, 0, 'h1FFFFF, 7, 'h1F);

        // With only three sprites provided, higher first sprites are refused.
        apply_settings(DIW_START_RST, 0, 256, 1, 3, 0);
        send_case(0, 10, 0, 0, 4, 5, 0, 0, 16, 'h01);
        send_case(0, 10, 0, 0, 4, -1, 3, 0, 16, 'h01);
        send_case(0, 10, 0, 0, 4, 1, 0, 0, 16, 'h04);
        restore_defaults();
    endtask

    task automatic test_register_settings();
        int i;
        apply_settings('h0000, 0, 0, 1, 0, 0);
        send_random(8, 5);
        apply_settings('hFFFF, 511, 511, 4, 8, 'h1FFFFF);
        send_random(30, 5);
        apply_settings('h0000, 0, 300, 2, 8, 'h0ABCDE);
        send_random(30, 5);
        apply_settings('h2C81, 100, 150, 3, 5, 'h155555);
        send_random(25, 5);
        for (i = 0; i < 3; i++)
        begin
            apply_settings($urandom_range(0, 'hFFFF), $urandom_range(0, 511),
                           $urandom_range(0, 511), $urandom_range(1, 4),
                           $urandom_range(0, 8), $urandom_range(0, ADDR_MASK));
            send_random(20, 5);
        end
        restore_defaults();
    endtask

    task automatic test_random_traffic();
        send_random(110, 5);
    endtask

    task automatic test_output_backpressure();
        sink_hold_req = 1'b1;
        sender_steady = 1'b1;
        send_random(24, 8);
        sender_steady = 1'b0;
    endtask

    task automatic test_calm_tail();
        calm_tail = 1'b1;
        send_random(40, 5);
    endtask

    initial
    begin : run_tests
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_register_settings();
        test_random_traffic();
        test_output_backpressure();
        test_calm_tail();

        in_valid <= 1'b0;
        for (n = 0; n < END_LIMIT && pending_words.size() != 0; n++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_words.size() != 0)
            report_mismatch("results never delivered, count", 0, pending_words.size());

        $display("Sent %0d placement requests and checked %0d sprite results.",
                 requests_sent, words_checked);
        $display("Made %0d register writes across %0d settings; %0d mismatches.",
                 regs_written, settings_applied, mismatch_count);
        if (mismatch_count == 0)
            $display("[sprite_control_word_builder] OK");
        else
            $display("[sprite_control_word_builder] ERROR");
        $finish;
    end

endmodule
